/* rtl/core/kmp_pkg.sv */
// Shared sizes, item classification codes and the queue entry type for the
// streaming pattern matcher. Has no dependencies; every RTL file imports it.
package kmp_pkg;

    localparam int PATTERN_DEPTH  = 64;
    localparam int POSITION_WIDTH = 16;
    localparam int START_W        = 16;

    localparam int IDX_W  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int LEN_W  = $clog2(PATTERN_DEPTH + 1);
    localparam int CALC_W = ((POSITION_WIDTH > LEN_W) ? POSITION_WIDTH : LEN_W) + 1;

    localparam logic [POSITION_WIDTH-1:0] POSITION_MAX = {POSITION_WIDTH{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PATTERN     = 2'd0,
        OP_PATTERN_NEW = 2'd1,
        OP_TEXT        = 2'd2,
        OP_TEXT_NEW    = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] symbol;
    } item_t;

endpackage

/* rtl/core/kmp_front.sv */
// Command front end: accepts transactions, classifies them into operations
// and holds them in a short queue for the back end. Depends on kmp_pkg.
module kmp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           kind,
    input  logic [7:0]     symbol,
    input  logic           first,
    output logic           busy,
    output logic           q_valid,
    output kmp_pkg::item_t q_item,
    input  logic           q_pop
);
    import kmp_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    item_t             new_item;

    assign busy    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.symbol = symbol;
        case ({kind, first})
            2'b00:   new_item.op = OP_PATTERN;
            2'b01:   new_item.op = OP_PATTERN_NEW;
            2'b10:   new_item.op = OP_TEXT;
            default: new_item.op = OP_TEXT_NEW;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (q_pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

/* rtl/core/kmp_back.sv */
// Execution back end: pattern and failure-link memories, prefix-function
// build, text scan with failure-link fallback and result register. Depends on kmp_pkg.
module kmp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  kmp_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          match_valid,
    output logic [kmp_pkg::START_W-1:0]   match_start,
    output logic                          position_saturated
);
    import kmp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FALL
    } state_t;

    logic [7:0]       pat_mem  [PATTERN_DEPTH];
    logic [LEN_W-1:0] fail_mem [PATTERN_DEPTH];
    logic [7:0]       p_rd_reg;
    logic [LEN_W-1:0] f_rd_reg;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [LEN_W-1:0]          border_reg, border_next;
    logic [LEN_W-1:0]          ml_reg, ml_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]          j_reg, j_next;
    logic [7:0]                sym_reg, sym_next;
    logic                      text_reg, text_next;
    logic [POSITION_WIDTH-1:0] index_reg, index_next;
    logic                      sat_reg, sat_next;
    logic                      match_valid_reg, match_valid_next;
    logic [START_W-1:0]        match_start_reg, match_start_next;
    logic                      sat_out_reg, sat_out_next;

    logic                      is_pattern;
    logic                      fresh;
    logic [LEN_W-1:0]          len_eff;
    logic [LEN_W-1:0]          ml_eff;
    logic [POSITION_WIDTH-1:0] pos_eff;
    logic                      sat_eff;
    logic                      step_back;
    logic [LEN_W-1:0]          j_adv;
    logic [LEN_W-1:0]          j_dec;
    logic [LEN_W-1:0]          len_dec;
    logic                      use_len_addr;
    logic [CALC_W-1:0]         idx_plus;
    logic [CALC_W-1:0]         len_wide;
    logic [CALC_W-1:0]         start_full;

    logic             p_we;
    logic [IDX_W-1:0] p_waddr;
    logic [IDX_W-1:0] p_raddr;
    logic             f_we;
    logic [IDX_W-1:0] f_waddr;
    logic [LEN_W-1:0] f_wdata;
    logic [IDX_W-1:0] f_raddr;

    assign match_valid        = match_valid_reg;
    assign match_start        = match_start_reg;
    assign position_saturated = sat_out_reg;

    always_comb
    begin
        case (q_item.op) inside
            OP_PATTERN, OP_PATTERN_NEW: is_pattern = 1'b1;
            default:                    is_pattern = 1'b0;
        endcase
        case (q_item.op) inside
            OP_PATTERN_NEW, OP_TEXT_NEW: fresh = 1'b1;
            default:                     fresh = 1'b0;
        endcase
    end

    assign len_eff   = (is_pattern && fresh) ? '0 : len_reg;
    assign ml_eff    = fresh ? '0 : ml_reg;
    assign pos_eff   = fresh ? '0 : pos_reg;
    assign sat_eff   = (pos_eff == POSITION_MAX);
    assign step_back = (j_reg != '0) && (p_rd_reg != sym_reg);
    assign j_adv     = (p_rd_reg == sym_reg) ? LEN_W'(j_reg + 1'b1) : j_reg;
    assign len_dec   = LEN_W'(len_reg - 1'b1);
    assign idx_plus  = CALC_W'(index_reg) + CALC_W'(1);
    assign len_wide  = CALC_W'(len_reg);
    assign start_full = (idx_plus >= len_wide) ? CALC_W'(idx_plus - len_wide) : '0;

    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        border_next      = border_reg;
        ml_next          = ml_reg;
        pos_next         = pos_reg;
        j_next           = j_reg;
        sym_next         = sym_reg;
        text_next        = text_reg;
        index_next       = index_reg;
        sat_next         = sat_reg;
        match_valid_next = 1'b0;
        match_start_next = match_start_reg;
        sat_out_next     = sat_out_reg;
        q_pop            = 1'b0;
        p_we             = 1'b0;
        p_waddr          = len_eff[IDX_W-1:0];
        f_we             = 1'b0;
        f_waddr          = len_reg[IDX_W-1:0];
        f_wdata          = j_adv;
        use_len_addr     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    sym_next = q_item.symbol;
                    if (is_pattern)
                    begin
                        text_next = 1'b0;
                        len_next  = len_eff;
                        if (fresh)
                        begin
                            border_next = '0;
                            ml_next     = '0;
                            pos_next    = '0;
                        end
                        if (len_eff < LEN_W'(PATTERN_DEPTH))
                        begin
                            p_we = 1'b1;
                            if (len_eff == '0)
                            begin
                                f_we        = 1'b1;
                                f_waddr     = '0;
                                f_wdata     = '0;
                                border_next = '0;
                                len_next    = LEN_W'(1);
                            end
                            else
                            begin
                                j_next     = border_reg;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        text_next  = 1'b1;
                        index_next = pos_eff;
                        sat_next   = sat_eff;
                        pos_next   = sat_eff ? pos_eff
                                             : POSITION_WIDTH'(pos_eff + 1'b1);
                        ml_next    = ml_eff;
                        if (len_reg != '0)
                        begin
                            j_next     = (ml_eff >= len_reg) ? '0 : ml_eff;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (step_back)
                begin
                    j_next = f_rd_reg;
                end
                else if (!text_reg)
                begin
                    border_next = j_adv;
                    f_we        = 1'b1;
                    len_next    = LEN_W'(len_reg + 1'b1);
                    state_next  = S_IDLE;
                end
                else if (j_adv == len_reg)
                begin
                    match_valid_next = 1'b1;
                    match_start_next = START_W'(start_full);
                    sat_out_next     = sat_reg;
                    use_len_addr     = 1'b1;
                    state_next       = S_FALL;
                end
                else
                begin
                    ml_next    = j_adv;
                    state_next = S_IDLE;
                end
            end
            S_FALL:
            begin
                ml_next    = f_rd_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        j_dec   = LEN_W'(j_next - 1'b1);
        p_raddr = j_next[IDX_W-1:0];
        f_raddr = use_len_addr ? len_dec[IDX_W-1:0] : j_dec[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            border_reg      <= '0;
            ml_reg          <= '0;
            pos_reg         <= '0;
            match_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            border_reg      <= border_next;
            ml_reg          <= ml_next;
            pos_reg         <= pos_next;
            match_valid_reg <= match_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg           <= j_next;
        sym_reg         <= sym_next;
        text_reg        <= text_next;
        index_reg       <= index_next;
        sat_reg         <= sat_next;
        match_start_reg <= match_start_next;
        sat_out_reg     <= sat_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pat_mem[p_waddr] <= sym_next;
        end
        p_rd_reg <= pat_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fail_mem[f_waddr] <= f_wdata;
        end
        f_rd_reg <= fail_mem[f_raddr];
    end

endmodule

/* rtl/core/kmp_stream_matcher.sv */
// Top level of the streaming pattern matcher: front end queue and back end.
// Depends on kmp_pkg, kmp_front and kmp_back.
//
// A transaction is taken when start is high and busy is low; kind selects a
// pattern byte or a text byte and first begins a new pattern or text. Each
// transaction is written into a two-entry queue when taken and dispatched
// from it to the back end. There a byte goes from the idle to the scan state,
// which repeats once per failure-link step, and a text byte that completes an
// occurrence goes on to a fall state that reloads the last failure entry. That
// loop is set by the single read port of the pattern and failure memories, one
// link per cycle; a new byte is taken only in the idle state. The first byte of
// a pattern, pattern bytes beyond the pattern depth and text bytes with an
// empty pattern stay in the idle state. The match result is shown for
// exactly one cycle on match_valid and cannot be stalled by the receiver.
module kmp_stream_matcher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [7:0]                  symbol,
    input  logic                        first,
    output logic                        match_valid,
    output logic [kmp_pkg::START_W-1:0] match_start,
    output logic                        position_saturated
);
    import kmp_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    kmp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .symbol  (symbol),
        .first   (first),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    kmp_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop),
        .match_valid        (match_valid),
        .match_start        (match_start),
        .position_saturated (position_saturated)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("back end took an item from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> q_valid)
        else $error("accepted transaction did not reach the queue");

    assert property (@(posedge clk) disable iff (!rst_n) match_valid |=> !match_valid)
        else $error("match strobe held for more than one cycle");

endmodule

/* dv/tb_kmp_stream_matcher.sv */
// Self-checking testbench for kmp_stream_matcher: drives pattern and text bytes,
// predicts every occurrence start and checks each result as it leaves the block.
// Depends on kmp_pkg and the kmp_stream_matcher RTL.
module tb_kmp_stream_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    import kmp_pkg::*;

    localparam bit KIND_PATTERN = 1'b0;
    localparam bit KIND_TEXT    = 1'b1;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 370;

    typedef struct {
        logic [START_W-1:0] start_index;
        logic               saturated;
    } occurrence_t;

    class occurrence_scoreboard;
        logic [7:0]                pattern_bytes [PATTERN_DEPTH];
        logic [LEN_W-1:0]          border_of [PATTERN_DEPTH];
        logic [LEN_W-1:0]          pattern_len;
        logic [LEN_W-1:0]          build_border;
        logic [LEN_W-1:0]          match_len;
        logic [POSITION_WIDTH-1:0] text_pos;
        occurrence_t               expected_starts[$];
        int unsigned               errors;

        function new();
            foreach (pattern_bytes[i])
            begin
                pattern_bytes[i] = '0;
                border_of[i]     = '0;
            end
            pattern_len  = '0;
            build_border = '0;
            match_len    = '0;
            text_pos     = '0;
            errors       = 0;
        endfunction

        function int extend_border(int j, logic [7:0] c);
            while (j > 0 && j < PATTERN_DEPTH && pattern_bytes[IDX_W'(j)] != c)
            begin
                j = border_of[IDX_W'(j - 1)];
            end
            if (j < PATTERN_DEPTH && pattern_bytes[IDX_W'(j)] == c)
            begin
                j++;
            end
            return j;
        endfunction

        function void note_byte(logic k, logic [7:0] c, logic f);
            int          j;
            int          index;
            int          begin_at;
            logic        sat;
            occurrence_t occ;
            if (k == KIND_PATTERN)
            begin
                if (f)
                begin
                    pattern_len  = '0;
                    build_border = '0;
                    match_len    = '0;
                    text_pos     = '0;
                end
                if (pattern_len < PATTERN_DEPTH)
                begin
                    pattern_bytes[pattern_len[IDX_W-1:0]] = c;
                    if (pattern_len == 0)
                    begin
                        build_border = '0;
                    end
                    else
                    begin
                        build_border = LEN_W'(extend_border(int'(build_border), c));
                    end
                    border_of[pattern_len[IDX_W-1:0]] = build_border;
                    pattern_len++;
                end
            end
            else
            begin
                if (f)
                begin
                    match_len = '0;
                    text_pos  = '0;
                end
                index = int'(text_pos);
                sat   = (text_pos == POSITION_MAX);
                if (!sat)
                begin
                    text_pos++;
                end
                if (pattern_len != 0)
                begin
                    j = int'(match_len);
                    if (j >= int'(pattern_len))
                    begin
                        j = 0;
                    end
                    j = extend_border(j, c);
                    if (j == int'(pattern_len))
                    begin
                        begin_at = (index + 1 >= int'(pattern_len))
                                 ? index + 1 - int'(pattern_len) : 0;
                        occ.start_index = START_W'(begin_at);
                        occ.saturated   = sat;
                        expected_starts = {expected_starts, occ};
                        j = border_of[IDX_W'(pattern_len - 1'b1)];
                    end
                    match_len = LEN_W'(j);
                end
            end
        endfunction

        function void check_occurrence(logic [START_W-1:0] st, logic sat);
            occurrence_t occ;
            if (expected_starts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual start %0d saturated %0b",
                         $time, st, sat);
            end
            else
            begin
                occ = expected_starts.pop_front();
                if (st !== occ.start_index)
                begin
                    errors++;
                    $display("%0t: match_start mismatch: expected %0d, actual %0d",
                             $time, occ.start_index, st);
                end
                if (sat !== occ.saturated)
                begin
                    errors++;
                    $display("%0t: position_saturated mismatch: expected %0b, actual %0b",
                             $time, occ.saturated, sat);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               kind = KIND_PATTERN;
    logic [7:0]         symbol = 8'h00;
    logic               first = 1'b0;
    logic               match_valid;
    logic [START_W-1:0] match_start;
    logic               position_saturated;

    occurrence_scoreboard occurrences;
    int unsigned          items_sent;
    int unsigned          gap_pct;
    int unsigned          cycle_count = 0;

    kmp_stream_matcher i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .kind               (kind),
        .symbol             (symbol),
        .first              (first),
        .match_valid        (match_valid),
        .match_start        (match_start),
        .position_saturated (position_saturated)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("kmp_stream_matcher verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (match_valid)
            begin
                occurrences.check_occurrence(match_start, position_saturated);
            end
            if (start && !busy)
            begin
                occurrences.note_byte(kind, symbol, first);
            end
        end
    end

    task automatic send_byte(input logic k, input logic [7:0] c, input logic f);
        start  <= 1'b1;
        kind   <= k;
        symbol <= c;
        first  <= f;
        do @(posedge clk); while (busy);
        items_sent++;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic run_session();
        logic [7:0]  alphabet [3];
        int unsigned nsym;
        int unsigned plen;
        int unsigned tlen;
        int unsigned roll;
        logic        is_long;
        roll    = $urandom_range(0, 99);
        is_long = (roll < 6);
        if (roll >= 94)
        begin
            repeat (10)
            begin
                send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 9) == 0));
            end
        end
        else
        begin
            nsym = is_long ? 1 : $urandom_range(1, 3);
            foreach (alphabet[i])
            begin
                alphabet[i] = 8'($urandom_range(0, 255));
            end
            plen = is_long ? $urandom_range(62, 68) : $urandom_range(1, 6);
            tlen = is_long ? $urandom_range(64, 90) : $urandom_range(4, 30);
            for (int i = 0; i < plen; i++)
            begin
                send_byte(KIND_PATTERN, alphabet[2'($urandom_range(0, nsym - 1))], (i == 0));
            end
            for (int i = 0; i < tlen; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    send_byte(KIND_PATTERN, alphabet[2'($urandom_range(0, nsym - 1))], 1'b0);
                end
                else if (roll < 11)
                begin
                    send_byte(KIND_TEXT, 8'($urandom_range(0, 255)), 1'b0);
                end
                else
                begin
                    send_byte(KIND_TEXT, alphabet[2'($urandom_range(0, nsym - 1))],
                              (i == 0) ? ($urandom_range(0, 9) != 0) : (roll < 15));
                end
            end
        end
    endtask

    initial
    begin
        int unsigned pct_list [3];
        occurrences = new();
        items_sent  = 0;
        gap_pct     = 0;
        pct_list    = '{27, 59, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pattern, extreme bytes, overlap, restart and growth.
        send_byte(KIND_TEXT, 8'h00, 1'b1);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_PATTERN, 8'hFF, 1'b1);
        send_byte(KIND_PATTERN, 8'h00, 1'b0);
        send_byte(KIND_PATTERN, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b1);
        send_byte(KIND_TEXT, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b1);
        send_byte(KIND_TEXT, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_PATTERN, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'h7F, 1'b0);
        send_byte(KIND_PATTERN, 8'h80, 1'b1);
        send_byte(KIND_TEXT, 8'h80, 1'b0);
        send_byte(KIND_TEXT, 8'h80, 1'b0);
        send_byte(KIND_TEXT, 8'h55, 1'b1);
        send_byte(KIND_TEXT, 8'h80, 1'b0);

        foreach (pct_list[p])
        begin
            gap_pct = pct_list[p];
            for (int unsigned goal = items_sent + PHASE_ITEMS; items_sent < goal; )
            begin
                run_session();
            end
        end
        start <= 1'b0;

        while (occurrences.expected_starts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (occurrences.expected_starts.size() != 0)
        begin
            occurrences.errors++;
            $display("%0t: leftover results: expected 0, actual %0d still pending",
                     $time, occurrences.expected_starts.size());
        end
        if (occurrences.errors == 0)
        begin
            $display("kmp_stream_matcher verification clean");
        end
        else
        begin
            $display("kmp_stream_matcher verification failed");
        end
        $finish;
    end

endmodule
